// ===== design/jnts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number scanner package
// Request types and a shared constant for the JSON number token scanner.
// ----------------------------------------------------------------------------
package jnts_pkg;

	// Width of the reported token length.
	localparam int LENGTH_W = 16;

	// One source character request.
	typedef struct packed {
		logic [7:0] ch;
		logic       start_req;
	} in_item_t;

	// One scan result request.
	typedef struct packed {
		logic                valid_res;
		logic [LENGTH_W-1:0] length;
		logic                is_uint;
	} out_item_t;

endpackage

// ===== design/jnts_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number scanner state machine
// Holds the token state and advances it by one character per step, raising
// a result on the character that ends the token.
// ----------------------------------------------------------------------------
module jnts_scan #(
	parameter int LEN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  jnts_pkg::in_item_t  item,
	input  logic                allow_hex,
	output logic                res_fire,
	output jnts_pkg::out_item_t res
);

	// Scan phases.
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_SIGN  = 4'd1;
	localparam logic [3:0] PH_INT   = 4'd2;
	localparam logic [3:0] PH_HEX   = 4'd3;
	localparam logic [3:0] PH_FRAC0 = 4'd4;
	localparam logic [3:0] PH_FRAC  = 4'd5;
	localparam logic [3:0] PH_EXP0  = 4'd6;
	localparam logic [3:0] PH_EXPS  = 4'd7;
	localparam logic [3:0] PH_EXP   = 4'd8;

	// Character codes.
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_LE    = 8'h65;
	localparam logic [7:0] CH_UE    = 8'h45;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;

	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0] LEN_ONE = LEN_BITS'(1);
	localparam logic [LEN_BITS-1:0] HEX_MIN = LEN_BITS'(2);
	localparam logic [31:0] OUT_MAX = 32'({jnts_pkg::LENGTH_W{1'b1}});

	logic [3:0]          phase_q, phase_d;
	logic [LEN_BITS-1:0] len_q, len_d, len_inc;
	logic                uint_q, uint_d;
	logic                lz_q, lz_d;
	logic                fin, ok;
	logic                c_dec, c_hex, c_exp, c_sign;
	logic [31:0]         len_ext;

	// Character classes of the current request.
	always_comb begin
		c_dec  = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
		c_hex  = c_dec || ((item.ch >= CH_LA) && (item.ch <= CH_LF)) ||
			((item.ch >= CH_UA) && (item.ch <= CH_UF));
		c_exp  = (item.ch == CH_LE) || (item.ch == CH_UE);
		c_sign = (item.ch == CH_PLUS) || (item.ch == CH_MINUS);
	end

	// Saturating length increment.
	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + LEN_ONE;

	// Next state for one character.
	always_comb begin
		phase_d = phase_q;
		len_d   = len_q;
		uint_d  = uint_q;
		lz_d    = lz_q;
		fin     = 1'b0;
		ok      = 1'b0;
		if (item.start_req) begin
			uint_d = 1'b1;
			lz_d   = 1'b0;
			len_d  = '0;
			if (item.ch == CH_MINUS) begin
				uint_d  = 1'b0;
				len_d   = LEN_ONE;
				phase_d = PH_SIGN;
			end else if (c_dec) begin
				lz_d    = (item.ch == CH_ZERO);
				len_d   = LEN_ONE;
				phase_d = PH_INT;
			end else begin
				fin = 1'b1;
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_SIGN: begin
					if (c_dec) begin
						len_d   = len_inc;
						phase_d = PH_INT;
					end else begin
						fin = 1'b1;
					end
				end
				PH_INT: begin
					lz_d = 1'b0;
					if (lz_q && allow_hex && (item.ch == CH_X)) begin
						len_d   = len_inc;
						phase_d = PH_HEX;
					end else if (c_dec) begin
						len_d = len_inc;
					end else if (item.ch == CH_DOT) begin
						uint_d  = 1'b0;
						len_d   = len_inc;
						phase_d = PH_FRAC0;
					end else if (c_exp) begin
						uint_d  = 1'b0;
						len_d   = len_inc;
						phase_d = PH_EXP0;
					end else begin
						fin = 1'b1;
						ok  = 1'b1;
					end
				end
				PH_HEX: begin
					if (c_hex) begin
						len_d = len_inc;
					end else begin
						fin = 1'b1;
						ok  = (len_q > HEX_MIN);
					end
				end
				PH_FRAC0: begin
					if (c_dec) begin
						len_d   = len_inc;
						phase_d = PH_FRAC;
					end else begin
						fin = 1'b1;
					end
				end
				PH_FRAC: begin
					if (c_dec) begin
						len_d = len_inc;
					end else if (c_exp) begin
						len_d   = len_inc;
						phase_d = PH_EXP0;
					end else begin
						fin = 1'b1;
						ok  = 1'b1;
					end
				end
				PH_EXP0: begin
					if (c_sign) begin
						len_d   = len_inc;
						phase_d = PH_EXPS;
					end else if (c_dec) begin
						len_d   = len_inc;
						phase_d = PH_EXP;
					end else begin
						fin = 1'b1;
					end
				end
				PH_EXPS: begin
					if (c_dec) begin
						len_d   = len_inc;
						phase_d = PH_EXP;
					end else begin
						fin = 1'b1;
					end
				end
				PH_EXP: begin
					if (c_dec) begin
						len_d = len_inc;
					end else begin
						fin = 1'b1;
						ok  = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		if (fin) begin
			phase_d = PH_IDLE;
		end
	end

	// Result fields; an invalid token reports all zeros.
	assign len_ext = 32'(len_q);
	always_comb begin
		res.valid_res = ok;
		res.is_uint   = ok & uint_q;
		res.length    = '0;
		if (ok) begin
			res.length = (len_ext > OUT_MAX) ? {jnts_pkg::LENGTH_W{1'b1}} :
				len_ext[jnts_pkg::LENGTH_W-1:0];
		end
	end
	assign res_fire = fin;

	// Token state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			uint_q  <= 1'b1;
			lz_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			len_q   <= len_d;
			uint_q  <= uint_d;
			lz_q    <= lz_d;
		end
	end

endmodule

// ===== design/jnts_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number scanner result register
// Holds one result request until the downstream side takes it.
// ----------------------------------------------------------------------------
module jnts_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  jnts_pkg::out_item_t load_data,
	output logic                free,
	output logic                valid,
	input  logic                stall,
	output jnts_pkg::out_item_t data
);

	logic                valid_q;
	jnts_pkg::out_item_t data_q;

	// The register can take a new request when empty or being drained.
	assign free = !valid_q || !stall;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= load_data;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// ===== design/json_number_token_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number token scanner
// Scans JSON number tokens one character per request and reports validity,
// length and whether the token is an unsigned integer.
// ----------------------------------------------------------------------------
// The scanner takes one character every clock cycle while no result is blocked
// by a stalled output. A character is captured in an input register, the token
// state machine consumes it when it can advance, and a result, if the character
// ends a token, is loaded into the output register as the state advances. The
// token state updates once per character, which sets the rate of one character
// per cycle. While a result is held by a stalled output, one more character is
// buffered; characters that produce no result keep flowing. allow_hex is written
// through cfg_wr_en and cfg_wr_data; the user must write it only while the block
// is idle, as the block itself does not enforce this.
module json_number_token_scanner_core #(
	parameter int LEN_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic                cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  jnts_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output jnts_pkg::out_item_t out_data
);

	logic                allow_hex_q;
	logic                valid_s1;
	jnts_pkg::in_item_t  item_s1;
	logic                res_fire;
	jnts_pkg::out_item_t res;
	logic                out_free;
	logic                advance;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_hex_q <= 1'b0;
		end else if (cfg_wr_en) begin
			allow_hex_q <= cfg_wr_data;
		end
	end

	// The held character moves on unless its result cannot be stored.
	assign advance  = valid_s1 && (!res_fire || out_free);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Token state machine.
	jnts_scan #(
		.LEN_BITS(LEN_BITS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.item     (item_s1),
		.allow_hex(allow_hex_q),
		.res_fire (res_fire),
		.res      (res)
	);

	// Result register.
	jnts_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_fire),
		.load_data(res),
		.free     (out_free),
		.valid    (out_valid),
		.stall    (out_stall),
		.data     (out_data)
	);

	// An invalid token reports zero length and no unsigned flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.valid_res |-> out_data.length == '0 && !out_data.is_uint)
		else $error("invalid result carries nonzero fields");

	// A valid token always has at least one character.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.valid_res |-> out_data.length != '0)
		else $error("valid result with zero length");

	// The input side stalls only behind a pending result that cannot be stored.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res_fire && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// A result handed to the output register is shown in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_fire |=> out_valid)
		else $error("result lost between scanner and output register");

endmodule

// ===== tb/tb_json_number_token_scanner_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON number token scanner testbench
// Streams characters into the scanner under random back-pressure. An in-bench
// model of the token grammar predicts each scan result. A checker compares
// every result with the oldest prediction, field by field. Directed tokens
// cover the grammar, the hex mode and the register change mid-token. Random
// traffic then runs in three idling modes.
// ----------------------------------------------------------------------------
module tb_json_number_token_scanner_core;

	localparam int LEN_BITS = 16;
	localparam longint unsigned LEN_MAX = (longint'(1) << LEN_BITS) - 1;
	localparam longint unsigned LENGTH_MAX = (longint'(1) << jnts_pkg::LENGTH_W) - 1;
	localparam int SETTLE_CYCLES = 6;

	// Character codes used by the grammar and by the stimulus.
	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_NEWLINE  = 8'h0A;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_COMMA    = 8'h2C;
	localparam logic [7:0] CH_MINUS    = 8'h2D;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_UP_A     = 8'h41;
	localparam logic [7:0] CH_UP_E     = 8'h45;
	localparam logic [7:0] CH_UP_F     = 8'h46;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;
	localparam logic [7:0] CH_LO_A     = 8'h61;
	localparam logic [7:0] CH_LO_E     = 8'h65;
	localparam logic [7:0] CH_LO_F     = 8'h66;
	localparam logic [7:0] CH_LO_X     = 8'h78;
	localparam logic [7:0] CH_RBRACE   = 8'h7D;

	// Phases of the token being scanned.
	typedef enum logic [3:0] {
		SC_IDLE, SC_SIGN, SC_INT, SC_HEX, SC_FRAC0, SC_FRAC, SC_EXP0, SC_EXPS, SC_EXP
	} scan_state_e;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_wr_data = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	jnts_pkg::in_item_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	jnts_pkg::out_item_t out_data;

	// Model state and configuration.
	scan_state_e     scan_state = SC_IDLE;
	longint unsigned scan_len = 0;
	logic            uint_flag = 1'b1;
	logic            lead_zero = 1'b0;
	logic            hex_en = 1'b0;

	jnts_pkg::out_item_t expected_tokens[$];
	int                  mismatches = 0;
	int                  live_chars = 0;
	int                  tx_idle_pct = 0;
	int                  rx_idle_pct = 0;
	jnts_pkg::out_item_t want;

	json_number_token_scanner_core #(
		.LEN_BITS(LEN_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_hex_digit(input logic [7:0] c);
		return is_digit(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
	endfunction

	function automatic void grow_token();
		if (scan_len < LEN_MAX)
			scan_len++;
	endfunction

	// Close the open token and queue the result it reports.
	function automatic void close_token(input logic ok);
		jnts_pkg::out_item_t r;
		r = '0;
		scan_state = SC_IDLE;
		if (ok) begin
			r.valid_res = 1'b1;
			r.length = (scan_len > LENGTH_MAX) ? '1 : scan_len[jnts_pkg::LENGTH_W-1:0];
			r.is_uint = uint_flag;
		end
		expected_tokens.push_back(r);
	endfunction

	// Advance the token model by one accepted character.
	function automatic void scan_char(input logic [7:0] c, input logic st);
		if (st) begin
			scan_len = 0;
			uint_flag = 1'b1;
			lead_zero = 1'b0;
			if (c == CH_MINUS) begin
				uint_flag = 1'b0;
				grow_token();
				scan_state = SC_SIGN;
			end else if (is_digit(c)) begin
				lead_zero = (c == CH_ZERO);
				grow_token();
				scan_state = SC_INT;
			end else begin
				close_token(1'b0);
			end
			return;
		end
		case (scan_state)
			SC_SIGN: begin
				if (is_digit(c)) begin
					grow_token();
					scan_state = SC_INT;
				end else begin
					close_token(1'b0);
				end
			end
			SC_INT: begin
				if (lead_zero && hex_en && c == CH_LO_X) begin
					lead_zero = 1'b0;
					grow_token();
					scan_state = SC_HEX;
				end else begin
					lead_zero = 1'b0;
					if (is_digit(c)) begin
						grow_token();
					end else if (c == CH_DOT) begin
						uint_flag = 1'b0;
						grow_token();
						scan_state = SC_FRAC0;
					end else if (c == CH_LO_E || c == CH_UP_E) begin
						uint_flag = 1'b0;
						grow_token();
						scan_state = SC_EXP0;
					end else begin
						close_token(1'b1);
					end
				end
			end
			SC_HEX: begin
				if (is_hex_digit(c))
					grow_token();
				else
					close_token(scan_len > 2);
			end
			SC_FRAC0: begin
				if (is_digit(c)) begin
					grow_token();
					scan_state = SC_FRAC;
				end else begin
					close_token(1'b0);
				end
			end
			SC_FRAC: begin
				if (is_digit(c)) begin
					grow_token();
				end else if (c == CH_LO_E || c == CH_UP_E) begin
					grow_token();
					scan_state = SC_EXP0;
				end else begin
					close_token(1'b1);
				end
			end
			SC_EXP0: begin
				if (c == CH_PLUS || c == CH_MINUS) begin
					grow_token();
					scan_state = SC_EXPS;
				end else if (is_digit(c)) begin
					grow_token();
					scan_state = SC_EXP;
				end else begin
					close_token(1'b0);
				end
			end
			SC_EXPS: begin
				if (is_digit(c)) begin
					grow_token();
					scan_state = SC_EXP;
				end else begin
					close_token(1'b0);
				end
			end
			SC_EXP: begin
				if (is_digit(c))
					grow_token();
				else
					close_token(1'b1);
			end
			default: begin
				scan_state = SC_IDLE;
			end
		endcase
	endfunction

	// The result side stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected result valid_res=%0b length=%0d is_uint=%0b",
					$time, out_data.valid_res, out_data.length, out_data.is_uint);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				if (out_data.valid_res !== want.valid_res) begin
					$display("%0t: valid_res expected %0b actual %0b",
						$time, want.valid_res, out_data.valid_res);
					mismatches++;
				end
				if (out_data.length !== want.length) begin
					$display("%0t: length expected %0d actual %0d",
						$time, want.length, out_data.length);
					mismatches++;
				end
				if (out_data.is_uint !== want.is_uint) begin
					$display("%0t: is_uint expected %0b actual %0b",
						$time, want.is_uint, out_data.is_uint);
					mismatches++;
				end
			end
		end
	end

	// Offer one character request and wait for it to be taken.
	task automatic send_char(input logic [7:0] c, input logic st);
		jnts_pkg::in_item_t item;
		item.ch = c;
		item.start_req = st;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		if (st || scan_state != SC_IDLE)
			live_chars++;
		scan_char(c, st);
	endtask

	// Send a string; the first character opens a token when asked.
	task automatic send_text(input string s, input logic opens);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], opens && i == 0);
	endtask

	// Hold off the source until every predicted result has come out.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_allow_hex(input logic v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		hex_en = v;
	endtask

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(9));
	endfunction

	function automatic logic [7:0] rand_hex_digit();
		int r;
		r = $urandom_range(21);
		if (r < 10)
			return CH_ZERO + 8'(r);
		else if (r < 16)
			return CH_LO_A + 8'(r - 10);
		return CH_UP_A + 8'(r - 16);
	endfunction

	function automatic logic [7:0] rand_terminator();
		case ($urandom_range(6))
			0: return CH_COMMA;
			1: return CH_SPACE;
			2: return CH_RBRACKET;
			3: return CH_RBRACE;
			4: return CH_NUL;
			5: return CH_NEWLINE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// One random token: mostly well formed, some cut short, some noise.
	task automatic send_random_token();
		logic [7:0] tok[$];
		int kind;
		int n;
		logic noise;
		tok = {};
		noise = 1'b0;
		kind = $urandom_range(99);
		if (kind < 70) begin
			if ($urandom_range(9) < 2) begin
				tok = {CH_ZERO, CH_LO_X};
				n = $urandom_range(1, 6);
				repeat (n) tok.push_back(rand_hex_digit());
			end else begin
				if ($urandom_range(3) == 0)
					tok.push_back(CH_MINUS);
				if ($urandom_range(4) == 0)
					tok.push_back(CH_ZERO);
				n = $urandom_range(1, 6);
				repeat (n) tok.push_back(rand_digit());
				if ($urandom_range(2) == 0) begin
					tok.push_back(CH_DOT);
					n = $urandom_range(1, 5);
					repeat (n) tok.push_back(rand_digit());
				end
				if ($urandom_range(2) == 0) begin
					tok.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
					if ($urandom_range(1))
						tok.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
					n = $urandom_range(1, 3);
					repeat (n) tok.push_back(rand_digit());
				end
			end
		end else if (kind < 85) begin
			case ($urandom_range(4))
				0: tok.push_back(CH_MINUS);
				1: tok = {rand_digit(), CH_DOT};
				2: tok = {rand_digit(), CH_LO_E};
				3: tok = {rand_digit(), CH_UP_E, CH_MINUS};
				default: tok = {CH_ZERO, CH_LO_X};
			endcase
		end else begin
			noise = 1'b1;
			n = $urandom_range(1, 4);
			repeat (n) tok.push_back(8'($urandom_range(255)));
		end
		foreach (tok[i]) begin
			if (noise)
				send_char(tok[i], $urandom_range(3) == 0);
			else
				send_char(tok[i], i == 0);
		end
		// Now and then the next token restarts this one without a terminator.
		if ($urandom_range(9) != 0)
			send_char(rand_terminator(), 1'b0);
		n = $urandom_range(2);
		repeat (n) send_char(8'($urandom_range(255)), 1'b0);
	endtask

	// Decimal grammar with hex mode off.
	task automatic test_decimal_tokens();
		tx_idle_pct = 22;
		rx_idle_pct = 49;
		send_text("-12.5e+7", 1'b1);
		send_char(CH_NUL, 1'b0);
		send_text("007,", 1'b1);
		send_text("1E-3]", 1'b1);
		send_text("-x", 1'b1);
		send_text("1.e", 1'b1);
		send_text("2e,", 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(CH_NUL, 1'b1);
		// With hex off, "0x" ends the token "0"; the idle character after it is ignored.
		send_text("0xa", 1'b1);
		// Restart in the middle of a token.
		send_text("12", 1'b1);
		send_text("3", 1'b1);
		send_char(8'hFF, 1'b0);
		drain_results();
	endtask

	// Hex tokens, the bare prefix and a register change inside a token.
	task automatic test_hex_tokens();
		write_allow_hex(1'b1);
		send_text("0xfF9g", 1'b1);
		send_text("0x,", 1'b1);
		send_text("-0x", 1'b1);
		send_char(CH_ZERO, 1'b1);
		write_allow_hex(1'b0);
		send_text("x", 1'b0);
		send_char(CH_ZERO, 1'b1);
		write_allow_hex(1'b1);
		send_text("xA0 ", 1'b0);
		drain_results();
	endtask

	task automatic test_random_traffic(input int tx_pct, input int rx_pct,
		input logic hex, input int target);
		int first;
		write_allow_hex(hex);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		first = live_chars;
		while (live_chars - first < target)
			send_random_token();
		drain_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decimal_tokens();
		test_hex_tokens();
		test_random_traffic(22, 49, 1'b1, 260);
		test_random_traffic(49, 22, 1'b0, 260);
		test_random_traffic(0, 0, 1'b1, 260);
		drain_results();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
design/jnts_pkg.sv
design/jnts_scan.sv
design/jnts_out_reg.sv
design/json_number_token_scanner_core.sv
tb/tb_json_number_token_scanner_core.sv
